// ----- design/g2e_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the geodetic to ECEF converter.
// No dependencies; used by g2e_sincos and geodetic_to_ecef.
package g2e_pkg;

  localparam int ANGLE_BITS = 32;
  localparam logic [63:0] TURN_MASK = ~64'd0 << (64 - ANGLE_BITS);

  localparam int IN_W  = 96;
  localparam int OUT_W = 104;

  localparam logic [63:0] ONE_Q60       = 64'd1 << 60;
  localparam logic [63:0] THREE_Q60     = 64'd3 << 60;
  localparam logic [63:0] PI_Q60        = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] SEMI_MAJOR_MM = 64'd6378137000;
  localparam logic [63:0] INV_FLAT_E9   = 64'd298257223563;
  localparam logic [63:0] SCALE_E9      = 64'd1000000000;
  localparam logic [63:0] RND_HALF      = 64'd1 << 19;

  localparam int PRO_LAT   = 5;
  localparam int TERMS     = 12;
  localparam int TERM_LAT  = 6;
  localparam int SC_LAT    = PRO_LAT + TERMS * TERM_LAT + 1;
  localparam int POST_LAT  = 46;
  localparam int TOTAL_LAT = 1 + SC_LAT + POST_LAT;

  typedef struct packed {
    logic [63:0] p00;
    logic [63:0] p01;
    logic [63:0] p10;
    logic [63:0] p11;
  } pp_t;

  function automatic pp_t mul_pp(logic [63:0] a, logic [63:0] b);
    pp_t r;
    r.p00 = 64'(a[31:0]) * 64'(b[31:0]);
    r.p01 = 64'(a[31:0]) * 64'(b[63:32]);
    r.p10 = 64'(a[63:32]) * 64'(b[31:0]);
    r.p11 = 64'(a[63:32]) * 64'(b[63:32]);
    return r;
  endfunction

  function automatic logic [127:0] mul_sum(pp_t p);
    return {64'd0, p.p00} + {32'd0, p.p01, 32'd0} + {32'd0, p.p10, 32'd0} + {p.p11, 64'd0};
  endfunction

  function automatic logic [63:0] mag(logic [63:0] v);
    return v[63] ? ~v + 64'd1 : v;
  endfunction

  function automatic logic [63:0] ecc_sq();
    logic [63:0]  rem;
    logic [63:0]  f;
    logic [127:0] p;
    rem = SCALE_E9;
    f   = 64'd0;
    for (int i = 0; i < 60; i++) begin
      rem = rem << 1;
      f   = f << 1;
      if (rem >= INV_FLAT_E9) begin
        rem  = rem - INV_FLAT_E9;
        f[0] = 1'b1;
      end
    end
    p = mul_sum(mul_pp(f, (ONE_Q60 << 1) - f));
    return p[123:60];
  endfunction

  localparam logic [63:0] E2   = ecc_sq();
  localparam logic [63:0] OME2 = ONE_Q60 - E2;

  typedef enum logic [4:0] {
    OP_MAG_SL, OP_PP_TT, OP_SUM_T, OP_PP_E2T, OP_W_INIT, OP_PP_II, OP_PP_WT, OP_G,
    OP_PP_IG, OP_SUM_INV, OP_PP_N, OP_SUM_N, OP_NH, OP_SUM_ZZ, OP_ADD_ZZ, OP_M1_MAG,
    OP_M1_PP, OP_M1_SUM, OP_M2_PP, OP_M2_SUM, OP_RND, OP_OUT
  } post_op_e;

  localparam post_op_e POST_OPS [POST_LAT] = '{
    OP_MAG_SL, OP_PP_TT, OP_SUM_T, OP_PP_E2T, OP_SUM_T, OP_W_INIT,
    OP_PP_II, OP_SUM_T, OP_PP_WT, OP_SUM_T, OP_G, OP_PP_IG, OP_SUM_INV,
    OP_PP_II, OP_SUM_T, OP_PP_WT, OP_SUM_T, OP_G, OP_PP_IG, OP_SUM_INV,
    OP_PP_II, OP_SUM_T, OP_PP_WT, OP_SUM_T, OP_G, OP_PP_IG, OP_SUM_INV,
    OP_PP_II, OP_SUM_T, OP_PP_WT, OP_SUM_T, OP_G, OP_PP_IG, OP_SUM_INV,
    OP_PP_N, OP_SUM_N, OP_NH, OP_SUM_ZZ, OP_ADD_ZZ, OP_M1_MAG,
    OP_M1_PP, OP_M1_SUM, OP_M2_PP, OP_M2_SUM, OP_RND, OP_OUT
  };

  typedef struct packed {
    logic [63:0] sl;
    logic [63:0] cl;
    logic [63:0] sn;
    logic [63:0] cn;
    logic [63:0] h;
    logic [63:0] t;
    logic [63:0] w;
    logic [63:0] inv;
    logic [63:0] g;
    logic [63:0] n;
    logic [63:0] nh;
    logic [63:0] zz;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] mc;
    logic [63:0] md;
    logic [63:0] me;
    logic [63:0] mf;
    logic        ngx;
    logic        ngy;
    logic        ngz;
    logic [33:0] ox;
    logic [33:0] oy;
    logic [33:0] oz;
    pp_t         ppa;
    pp_t         ppb;
    pp_t         ppc;
  } post_t;

  function automatic post_t post_step(post_op_e op, post_t p);
    post_t        r;
    logic [127:0] sa;
    logic [127:0] sb;
    logic [127:0] sc;
    r  = p;
    sa = mul_sum(p.ppa);
    sb = mul_sum(p.ppb);
    sc = mul_sum(p.ppc);
    unique case (op)
      OP_MAG_SL:  r.t = mag(p.sl);
      OP_PP_TT:   r.ppa = mul_pp(p.t, p.t);
      OP_SUM_T:   r.t = sa[123:60];
      OP_PP_E2T:  r.ppa = mul_pp(E2, p.t);
      OP_W_INIT: begin
        r.w   = ONE_Q60 - p.t;
        r.inv = ONE_Q60 + (p.t >> 1);
      end
      OP_PP_II:   r.ppa = mul_pp(p.inv, p.inv);
      OP_PP_WT:   r.ppa = mul_pp(p.w, p.t);
      OP_G:       r.g = THREE_Q60 - p.t;
      OP_PP_IG:   r.ppa = mul_pp(p.inv, p.g);
      OP_SUM_INV: r.inv = {1'b0, sa[123:61]};
      OP_PP_N:    r.ppa = mul_pp(SEMI_MAJOR_MM, p.inv);
      OP_SUM_N:   r.n = sa[103:40];
      OP_NH: begin
        r.nh  = p.n + p.h;
        r.ppb = mul_pp(p.n, OME2);
      end
      OP_SUM_ZZ:  r.zz = sb[123:60];
      OP_ADD_ZZ:  r.zz = p.zz + p.h;
      OP_M1_MAG: begin
        r.ma  = mag(p.nh);
        r.mb  = mag(p.cl);
        r.mc  = mag(p.cn);
        r.md  = mag(p.sn);
        r.me  = mag(p.zz);
        r.mf  = mag(p.sl);
        r.ngx = p.nh[63] ^ p.cl[63] ^ p.cn[63];
        r.ngy = p.nh[63] ^ p.cl[63] ^ p.sn[63];
        r.ngz = p.zz[63] ^ p.sl[63];
      end
      OP_M1_PP: begin
        r.ppa = mul_pp(p.ma, p.mb);
        r.ppc = mul_pp(p.me, p.mf);
      end
      OP_M1_SUM: begin
        r.ma = sa[123:60];
        r.me = sc[123:60];
      end
      OP_M2_PP: begin
        r.ppa = mul_pp(p.ma, p.mc);
        r.ppb = mul_pp(p.ma, p.md);
      end
      OP_M2_SUM: begin
        r.mc = sa[123:60];
        r.md = sb[123:60];
      end
      OP_RND: begin
        r.mc = (p.mc + RND_HALF) >> 20;
        r.md = (p.md + RND_HALF) >> 20;
        r.me = (p.me + RND_HALF) >> 20;
      end
      OP_OUT: begin
        r.ox = p.ngx ? ~p.mc[33:0] + 34'd1 : p.mc[33:0];
        r.oy = p.ngy ? ~p.md[33:0] + 34'd1 : p.md[33:0];
        r.oz = p.ngz ? ~p.me[33:0] + 34'd1 : p.me[33:0];
      end
    endcase
    return r;
  endfunction

endpackage

// ----- design/g2e_sincos.sv -----
`timescale 1ns / 1ps
// Pipelined sine and cosine of a 64-bit turn fraction, Q60 results, twelve series terms.
// Depends on g2e_pkg.
module g2e_sincos (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] turn_i,
  output logic [63:0] sin_o,
  output logic [63:0] cos_o
);
  import g2e_pkg::*;

  typedef struct packed {
    logic [1:0]  quad;
    logic        upper;
    logic [63:0] x2;
    logic [63:0] st;
    logic [63:0] ct;
    logic [63:0] ss;
    logic [63:0] cc;
    logic [63:0] ms;
    logic [63:0] mc;
    logic [63:0] rs;
    logic [63:0] rc;
    logic [63:0] q0s;
    logic [63:0] q0c;
    pp_t         pps;
    pp_t         ppc;
  } sc_t;

  sc_t         pro_d [PRO_LAT];
  sc_t         pro_q [PRO_LAT];
  sc_t         trm_d [TERMS][TERM_LAT];
  sc_t         trm_q [TERMS][TERM_LAT];
  logic [62:0] psi;
  logic [63:0] sel_s;
  logic [63:0] sel_c;
  logic [63:0] sin_q;
  logic [63:0] cos_q;
  logic [127:0] pro_sum2;
  logic [127:0] pro_sum4;

  assign psi = turn_i[61] ? (63'd1 << 62) - {1'b0, turn_i[61:0]} : {1'b0, turn_i[61:0]};
  assign pro_sum2 = mul_sum(pro_q[1].pps);
  assign pro_sum4 = mul_sum(pro_q[3].pps);

  always_comb begin
    pro_d[0]       = '0;
    pro_d[0].quad  = turn_i[63:62];
    pro_d[0].upper = turn_i[61];
    pro_d[0].st    = {1'b0, psi};
    pro_d[1]       = pro_q[0];
    pro_d[1].pps   = mul_pp(pro_q[0].st, PI_Q60);
    pro_d[2]       = pro_q[1];
    pro_d[2].ss    = pro_sum2[126:63];
    pro_d[3]       = pro_q[2];
    pro_d[3].pps   = mul_pp(pro_q[2].ss, pro_q[2].ss);
    pro_d[4]       = pro_q[3];
    pro_d[4].x2    = pro_sum4[123:60];
    pro_d[4].st    = pro_q[3].ss;
    pro_d[4].ct    = ONE_Q60;
    pro_d[4].cc    = ONE_Q60;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pro_q <= pro_d;
    end
  end

  for (genvar k = 0; k < TERMS; k++) begin : g_term
    localparam logic [9:0]  DS  = 10'((2 * k + 2) * (2 * k + 3));
    localparam logic [9:0]  DC  = 10'((2 * k + 1) * (2 * k + 2));
    localparam logic [63:0] MS  = 64'hFFFF_FFFF_FFFF_FFFF / {54'd0, DS};
    localparam logic [63:0] MC  = 64'hFFFF_FFFF_FFFF_FFFF / {54'd0, DC};
    localparam bit          SUB = (k % 2 == 0);

    sc_t          src;
    logic [127:0] sum_s1;
    logic [127:0] sum_c1;
    logic [127:0] sum_s3;
    logic [127:0] sum_c3;
    logic [63:0]  qs;
    logic [63:0]  qc;

    if (k == 0) begin : g_first
      assign src = pro_q[PRO_LAT-1];
    end else begin : g_next
      assign src = trm_q[k-1][TERM_LAT-1];
    end

    assign sum_s1 = mul_sum(trm_q[k][0].pps);
    assign sum_c1 = mul_sum(trm_q[k][0].ppc);
    assign sum_s3 = mul_sum(trm_q[k][2].pps);
    assign sum_c3 = mul_sum(trm_q[k][2].ppc);
    assign qs = trm_q[k][4].q0s + 64'(trm_q[k][4].rs >= {54'd0, DS});
    assign qc = trm_q[k][4].q0c + 64'(trm_q[k][4].rc >= {54'd0, DC});

    always_comb begin
      trm_d[k][0]     = src;
      trm_d[k][0].pps = mul_pp(src.st, src.x2);
      trm_d[k][0].ppc = mul_pp(src.ct, src.x2);
      trm_d[k][1]     = trm_q[k][0];
      trm_d[k][1].ms  = sum_s1[123:60];
      trm_d[k][1].mc  = sum_c1[123:60];
      trm_d[k][2]     = trm_q[k][1];
      trm_d[k][2].pps = mul_pp(trm_q[k][1].ms, MS);
      trm_d[k][2].ppc = mul_pp(trm_q[k][1].mc, MC);
      trm_d[k][3]     = trm_q[k][2];
      trm_d[k][3].q0s = sum_s3[127:64];
      trm_d[k][3].q0c = sum_c3[127:64];
      trm_d[k][4]     = trm_q[k][3];
      trm_d[k][4].rs  = trm_q[k][3].ms - 64'(trm_q[k][3].q0s * {54'd0, DS});
      trm_d[k][4].rc  = trm_q[k][3].mc - 64'(trm_q[k][3].q0c * {54'd0, DC});
      trm_d[k][5]     = trm_q[k][4];
      trm_d[k][5].st  = qs;
      trm_d[k][5].ct  = qc;
      trm_d[k][5].ss  = SUB ? trm_q[k][4].ss - qs : trm_q[k][4].ss + qs;
      trm_d[k][5].cc  = SUB ? trm_q[k][4].cc - qc : trm_q[k][4].cc + qc;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        trm_q[k] <= trm_d[k];
      end
    end
  end

  assign sel_s = trm_q[TERMS-1][TERM_LAT-1].upper ? trm_q[TERMS-1][TERM_LAT-1].cc
                                                  : trm_q[TERMS-1][TERM_LAT-1].ss;
  assign sel_c = trm_q[TERMS-1][TERM_LAT-1].upper ? trm_q[TERMS-1][TERM_LAT-1].ss
                                                  : trm_q[TERMS-1][TERM_LAT-1].cc;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      unique case (trm_q[TERMS-1][TERM_LAT-1].quad)
        2'd0: begin
          sin_q <= sel_s;
          cos_q <= sel_c;
        end
        2'd1: begin
          sin_q <= sel_c;
          cos_q <= 64'd0 - sel_s;
        end
        2'd2: begin
          sin_q <= 64'd0 - sel_s;
          cos_q <= 64'd0 - sel_c;
        end
        2'd3: begin
          sin_q <= 64'd0 - sel_c;
          cos_q <= sel_s;
        end
      endcase
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// ----- design/geodetic_to_ecef.sv -----
`timescale 1ns / 1ps
// Top level of the WGS84 geodetic to ECEF converter with stream ports.
// Depends on g2e_pkg and g2e_sincos.

// The block accepts one position beat in every clock cycle unless the output is stalled,
// and returns one ECEF beat for each, in order. A beat passes one input stage, 78 stages
// of sine and cosine (six for each of the twelve series terms, plus prologue and output)
// and 46 stages for the inverse square root (four Newton steps), the radius and products.
// When the output is stalled the whole pipeline holds, and no beat is lost or repeated.
module geodetic_to_ecef (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // latitude [31:0], longitude [63:32], altitude [94:64], zero pad [95]
  input  logic [g2e_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // ecef_x [33:0], ecef_y [67:34], ecef_z [101:68], zero pad [103:102]
  output logic [g2e_pkg::OUT_W-1:0]  m_axis_tdata
);
  import g2e_pkg::*;

  typedef struct packed {
    logic [63:0] lat;
    logic [63:0] lon;
    logic [63:0] h;
  } in_t;

  logic                 en;
  logic [TOTAL_LAT-1:0] vld_q;
  in_t                  in_q;
  logic [63:0]          h_dly_q [SC_LAT];
  logic [63:0]          slat;
  logic [63:0]          clat;
  logic [63:0]          slon;
  logic [63:0]          clon;
  post_t                entry;
  post_t                post_d [POST_LAT];
  post_t                post_q [POST_LAT];

  assign en            = !vld_q[TOTAL_LAT-1] || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TOTAL_LAT-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q.lat <= {s_axis_tdata[31:0], 32'd0} & TURN_MASK;
      in_q.lon <= {s_axis_tdata[63:32], 32'd0} & TURN_MASK;
      in_q.h   <= {{13{s_axis_tdata[94]}}, s_axis_tdata[94:64], 20'd0};
      h_dly_q[0] <= in_q.h;
      for (int j = 1; j < SC_LAT; j++) begin
        h_dly_q[j] <= h_dly_q[j-1];
      end
    end
  end

  g2e_sincos u_lat (
    .clk_i  (clk_i),
    .en_i   (en),
    .turn_i (in_q.lat),
    .sin_o  (slat),
    .cos_o  (clat)
  );

  g2e_sincos u_lon (
    .clk_i  (clk_i),
    .en_i   (en),
    .turn_i (in_q.lon),
    .sin_o  (slon),
    .cos_o  (clon)
  );

  always_comb begin
    entry    = '0;
    entry.sl = slat;
    entry.cl = clat;
    entry.sn = slon;
    entry.cn = clon;
    entry.h  = h_dly_q[SC_LAT-1];
  end

  for (genvar i = 0; i < POST_LAT; i++) begin : g_post
    if (i == 0) begin : g_first
      assign post_d[i] = post_step(POST_OPS[i], entry);
    end else begin : g_next
      assign post_d[i] = post_step(POST_OPS[i], post_q[i-1]);
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        post_q[i] <= post_d[i];
      end
    end
  end

  assign m_axis_tvalid = vld_q[TOTAL_LAT-1];
  assign m_axis_tdata  = {2'b00, post_q[POST_LAT-1].oz, post_q[POST_LAT-1].oy,
                          post_q[POST_LAT-1].ox};

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Result beat changed while stalled.");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("Accepted beat did not enter the pipeline.");

  a_frozen_valids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("Valid bits moved during a stall.");

endmodule
